// ===== rtl/core/pasa_pkg.sv =====
// Shared widths, sizes and status codes for the page-aligned stack allocator.
// No dependencies; used by every file in rtl/core.
`default_nettype none

package pasa_pkg;

   // Field widths
   localparam int ADDR_W = 48;
   localparam int BYTES_W = 41;
   localparam int STATUS_W = 3;
   localparam int CSR_IDX_W = 2;

   // Record store geometry
   localparam int MAX_BLOCKS = 64;
   localparam int REC_AW = $clog2(MAX_BLOCKS);
   localparam int CNT_W = REC_AW + 1;

   // Page rounding (page size is a power of two)
   localparam int PAGE_BYTES = 4096;
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int SIZE_W = BYTES_W + 1;
   localparam int SUM_W = BYTES_W + 2;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 3'd0,
      ST_OOM   = 3'd1,
      ST_EMPTY = 3'd2,
      ST_WRONG = 3'd3,
      ST_FULL  = 3'd4
   } status_type;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ADDRESS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY = 2'd1;

endpackage

`default_nettype wire

// ===== rtl/core/pasa_rec_store.sv =====
// Record store: block start offsets, one write port and one registered read port.
// Depends on pasa_pkg for depth and width.
`default_nettype none

module pasa_rec_store (
   input  wire logic                            clock,
   input  wire logic                            wr_en,
   input  wire logic [pasa_pkg::REC_AW-1:0]     wr_addr,
   input  wire logic [pasa_pkg::BYTES_W-1:0]    wr_data,
   input  wire logic                            rd_en,
   input  wire logic [pasa_pkg::REC_AW-1:0]     rd_addr,
   output logic      [pasa_pkg::BYTES_W-1:0]    rd_data
);

   logic [pasa_pkg::BYTES_W-1:0] mem_ff [pasa_pkg::MAX_BLOCKS];
   logic [pasa_pkg::BYTES_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/page_aligned_stack_allocator_top.sv =====
// Page-aligned LIFO stack allocator: control, bookkeeping and result register.
// Depends on pasa_pkg and pasa_rec_store.
//
// Usage:
//   Request channel (req_*): mode 0 allocates request_bytes rounded up to a
//   4096-byte page; mode 1 frees free_address, which must be the most recent
//   live block. Result channel (rsp_*): one result per request with the block
//   address, status, used, free and peak byte counts.
//   Configuration port (csr_*): index 0 base address, index 1 capacity; write
//   only while no request is in flight. Other indexes are ignored.
// Sequence:
//   The accept cycle in S_IDLE reads the top record from the record store
//   (registered read port); S_EXEC then checks, updates the state, writes the
//   record back on a good allocation and loads the result register, held off
//   while a stalled result still waits. The next request is accepted only back
//   in S_IDLE, so a new request is taken only once the last one is done.
//   rsp_valid rises at the edge that leaves S_EXEC.
// Reset: clears registers, top, block count, peak and the result valid; the
//   record store needs no clearing. When rsp_stall holds, the result waits in
//   its register; one more request can be accepted and then waits its turn.
`default_nettype none

module page_aligned_stack_allocator_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Request channel
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_mode,
   input  wire logic [pasa_pkg::BYTES_W-1:0]      req_request_bytes,
   input  wire logic [pasa_pkg::ADDR_W-1:0]       req_free_address,
   // Result channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic      [pasa_pkg::ADDR_W-1:0]       rsp_block_address,
   output logic      [pasa_pkg::STATUS_W-1:0]     rsp_status,
   output logic      [pasa_pkg::BYTES_W-1:0]      rsp_used_bytes,
   output logic      [pasa_pkg::BYTES_W-1:0]      rsp_free_bytes,
   output logic      [pasa_pkg::BYTES_W-1:0]      rsp_peak_bytes,
   // Configuration port
   input  wire logic                              csr_wr_en,
   input  wire logic [pasa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [pasa_pkg::ADDR_W-1:0]       csr_wr_data
);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type                        state_ff, state_in;
   logic [pasa_pkg::ADDR_W-1:0]      base_ff;
   logic [pasa_pkg::BYTES_W-1:0]     cap_ff;
   logic [pasa_pkg::BYTES_W-1:0]     top_ff, top_in;
   logic [pasa_pkg::CNT_W-1:0]       count_ff, count_in;
   logic [pasa_pkg::BYTES_W-1:0]     peak_ff, peak_in;

   // Captured request
   logic                             mode_ff;
   logic [pasa_pkg::SIZE_W-1:0]      size_ff, size_in;
   logic [pasa_pkg::ADDR_W-1:0]      faddr_ff;

   // Result register
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [pasa_pkg::ADDR_W-1:0]      rsp_addr_ff, rsp_addr_in;
   pasa_pkg::status_type             rsp_status_ff, rsp_status_in;
   logic [pasa_pkg::BYTES_W-1:0]     rsp_used_ff;
   logic [pasa_pkg::BYTES_W-1:0]     rsp_peak_ff;

   logic                             req_accept;
   logic                             exec_fire;
   logic [pasa_pkg::SIZE_W-1:0]      round_sum;
   logic [pasa_pkg::CNT_W-1:0]       count_m1;
   logic [pasa_pkg::BYTES_W-1:0]     last_start;
   logic [pasa_pkg::SUM_W-1:0]       new_top;
   logic                             oom, full, empty, addr_match;
   logic                             alloc_ok, free_ok;
   logic [pasa_pkg::ADDR_W-1:0]      last_addr;

   // Handshake
   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && (state_ff == S_IDLE);
   assign exec_fire  = (state_ff == S_EXEC) && !(rsp_valid_ff && rsp_stall);

   // Round the request up to a page at accept time
   assign round_sum = {1'b0, req_request_bytes} + pasa_pkg::SIZE_W'(pasa_pkg::PAGE_BYTES - 1);
   assign size_in   = (round_sum >> pasa_pkg::PAGE_SHIFT) << pasa_pkg::PAGE_SHIFT;

   // Top record address
   assign count_m1 = count_ff - pasa_pkg::CNT_W'(1);

   pasa_rec_store u_rec_store (
      .clock   (clock),
      .wr_en   (exec_fire && alloc_ok),
      .wr_addr (count_ff[pasa_pkg::REC_AW-1:0]),
      .wr_data (top_ff),
      .rd_en   (req_accept),
      .rd_addr (count_m1[pasa_pkg::REC_AW-1:0]),
      .rd_data (last_start)
   );

   // Allocation checks
   assign new_top = {2'b00, top_ff} + {1'b0, size_ff};
   assign oom     = new_top > {2'b00, cap_ff};
   assign full    = count_ff >= pasa_pkg::CNT_W'(pasa_pkg::MAX_BLOCKS);
   assign alloc_ok = !mode_ff && !oom && !full;

   // Free checks
   assign empty      = (count_ff == '0);
   assign last_addr  = base_ff + {{(pasa_pkg::ADDR_W-pasa_pkg::BYTES_W){1'b0}}, last_start};
   assign addr_match = (last_addr == faddr_ff);
   assign free_ok    = mode_ff && !empty && addr_match;

   // Next state of the bookkeeping and the result
   always_comb begin
      top_in        = top_ff;
      count_in      = count_ff;
      peak_in       = peak_ff;
      rsp_addr_in   = '0;
      rsp_status_in = pasa_pkg::ST_OK;
      if (!mode_ff) begin
         if (oom) begin
            rsp_status_in = pasa_pkg::ST_OOM;
         end else if (full) begin
            rsp_status_in = pasa_pkg::ST_FULL;
         end else begin
            rsp_addr_in = base_ff
               + {{(pasa_pkg::ADDR_W-pasa_pkg::BYTES_W){1'b0}}, top_ff};
            top_in   = new_top[pasa_pkg::BYTES_W-1:0];
            count_in = count_ff + pasa_pkg::CNT_W'(1);
            if (new_top[pasa_pkg::BYTES_W-1:0] > peak_ff) begin
               peak_in = new_top[pasa_pkg::BYTES_W-1:0];
            end
         end
      end else begin
         if (empty) begin
            rsp_status_in = pasa_pkg::ST_EMPTY;
         end else if (!free_ok) begin
            rsp_status_in = pasa_pkg::ST_WRONG;
         end else begin
            top_in   = last_start;
            count_in = count_m1;
         end
      end
   end

   // Sequencer next state and result valid
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (exec_fire) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state, configuration and bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         base_ff      <= '0;
         cap_ff       <= '0;
         top_ff       <= '0;
         count_ff     <= '0;
         peak_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en && (csr_index == pasa_pkg::CSR_BASE_ADDRESS)) begin
            base_ff <= csr_wr_data;
         end
         if (csr_wr_en && (csr_index == pasa_pkg::CSR_CAPACITY)) begin
            cap_ff <= csr_wr_data[pasa_pkg::BYTES_W-1:0];
         end
         if (exec_fire) begin
            top_ff   <= top_in;
            count_ff <= count_in;
            peak_ff  <= peak_in;
         end
      end
   end

   // Request capture and result payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         mode_ff  <= req_mode;
         size_ff  <= size_in;
         faddr_ff <= req_free_address;
      end
      if (exec_fire) begin
         rsp_addr_ff   <= rsp_addr_in;
         rsp_status_ff <= rsp_status_in;
         rsp_used_ff   <= top_in;
         rsp_peak_ff   <= peak_in;
      end
   end

   // Outputs; free bytes follow from the held top and the stable capacity
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_block_address = rsp_addr_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_used_bytes    = rsp_used_ff;
   assign rsp_peak_bytes    = rsp_peak_ff;
   assign rsp_free_bytes    = (cap_ff > rsp_used_ff) ? (cap_ff - rsp_used_ff) : '0;

endmodule

`default_nettype wire
